// File: sv/adv_data_uuid_search_assert.svh
// Assertion macros shared by the UUID search RTL.
// Defining NO_ASSERTIONS turns every macro into an empty body.
`ifndef ADV_DATA_UUID_SEARCH_ASSERT_SVH
`define ADV_DATA_UUID_SEARCH_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define ADUS_ASSERT_DIS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ADUS_ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ADUS_ASSERT_DIS(lbl, clk, rst_n, prop, msg)
`define ADUS_ASSERT_CLK(lbl, clk, prop, msg)
`endif

`endif

// File: sv/adus_pkg.sv
// Shared types and constants of the advertising data UUID search.
// No dependencies; used by the interfaces' users, the parser and the top level.
package adus_pkg;

  typedef enum logic [1:0] {
    PH_LEN  = 2'd0,
    PH_TYPE = 2'd1,
    PH_DATA = 2'd2
  } phase_e;

  typedef enum logic [0:0] {
    CFG_TARGET_HIGH = 1'b0,
    CFG_TARGET_LOW  = 1'b1
  } cfg_idx_e;

  localparam logic [7:0] AD_TYPE_UUID16_PART  = 8'h02;
  localparam logic [7:0] AD_TYPE_UUID16_FULL  = 8'h03;
  localparam logic [7:0] AD_TYPE_UUID128_PART = 8'h06;
  localparam logic [7:0] AD_TYPE_UUID128_FULL = 8'h07;

  localparam int unsigned UUID128_BYTES = 16;
  localparam int unsigned ENTRY_IDX_W   = $clog2(UUID128_BYTES);
  localparam int unsigned CFG_W         = 64;

  // Fixed parts of the Bluetooth base UUID around the 16-bit alias.
  localparam logic [31:0] BASE_HIGH_LOW32 = 32'h0000_1000;
  localparam logic [63:0] BASE_LOW        = 64'h8000_0080_5F9B_34FB;

  typedef struct packed {
    logic [7:0] ad_byte;
    logic       final_byte;
  } beat_t;

endpackage

// File: sv/adus_if.sv
// Valid/ready channel interfaces for payload bytes in and search results out.
// Standalone; no package dependency.
interface adus_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ad_byte;
  logic       final_byte;

  modport source(output valid, output ad_byte, output final_byte, input ready);
  modport sink(input valid, input ad_byte, input final_byte, output ready);
endinterface

interface adus_out_if;
  logic valid;
  logic ready;
  logic uuid_found;

  modport source(output valid, output uuid_found, input ready);
  modport sink(input valid, input uuid_found, output ready);
endinterface

// File: sv/adus_parser.sv
// Element parser and UUID comparator: walks length/type/data elements one byte per step.
// Depends on adus_pkg and the assertion macro header.
`include "adv_data_uuid_search_assert.svh"

module adus_parser import adus_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  beat_t       beat_i,
  input  logic [63:0] target_high_i,
  input  logic [63:0] target_low_i,
  output logic        found_o
);

  phase_e                 phase_q, phase_d;
  logic [7:0]             bytes_left_q, bytes_left_d;
  logic [7:0]             type_q, type_d;
  logic [ENTRY_IDX_W-1:0] idx_q, idx_d;
  logic [7:0]             first_q, first_d;
  logic                   eq_q, eq_d;
  logic                   found_q, found_d;

  logic                   is16;
  logic                   is128;
  logic                   base_form;
  logic                   pair_match;
  logic [127:0]           target_le;
  logic [7:0]             target_byte;
  logic                   byte_eq;
  logic [7:0]             left_dec;
  logic                   entry_last;
  logic                   hit;

  localparam logic [ENTRY_IDX_W-1:0] IdxLast = ENTRY_IDX_W'(UUID128_BYTES - 1);

  assign is16  = (type_q == AD_TYPE_UUID16_PART) || (type_q == AD_TYPE_UUID16_FULL);
  assign is128 = (type_q == AD_TYPE_UUID128_PART) || (type_q == AD_TYPE_UUID128_FULL);

  // A 16-bit entry can only match when the target has the base UUID form.
  assign base_form  = (target_high_i[63:48] == 16'h0000) &&
                      (target_high_i[31:0] == BASE_HIGH_LOW32) &&
                      (target_low_i == BASE_LOW);
  assign pair_match = base_form && (target_high_i[47:32] == {beat_i.ad_byte, first_q});

  // Over-the-air order is little-endian, so byte k sits at bits 8k of the joined target.
  assign target_le   = {target_high_i, target_low_i};
  assign target_byte = target_le[{idx_q, 3'b000} +: 8];
  assign byte_eq     = (beat_i.ad_byte == target_byte);
  assign left_dec    = bytes_left_q - 8'd1;
  assign entry_last  = (idx_q == IdxLast);

  assign hit = step_i && (phase_q == PH_DATA) &&
               ((is16 && (idx_q != '0) && pair_match) ||
                (is128 && entry_last && eq_q && byte_eq));

  assign found_o = found_q || hit;

  always_comb begin
    phase_d = phase_q;
    if (step_i) begin
      unique case (phase_q)
        PH_TYPE: begin
          phase_d = (bytes_left_q == 8'd0) ? PH_LEN : PH_DATA;
        end
        PH_DATA: begin
          if (left_dec == 8'd0) begin
            phase_d = PH_LEN;
          end
        end
        default: begin
          phase_d = (beat_i.ad_byte != 8'd0) ? PH_TYPE : PH_LEN;
        end
      endcase
      if (beat_i.final_byte) begin
        phase_d = PH_LEN;
      end
    end
  end

  always_comb begin
    bytes_left_d = bytes_left_q;
    type_d       = type_q;
    idx_d        = idx_q;
    first_d      = first_q;
    eq_d         = eq_q;
    found_d      = found_q;
    if (step_i) begin
      unique case (phase_q)
        PH_TYPE: begin
          type_d = beat_i.ad_byte;
          idx_d  = '0;
          eq_d   = 1'b1;
        end
        PH_DATA: begin
          if (is16) begin
            if (idx_q == '0) begin
              first_d = beat_i.ad_byte;
              idx_d   = ENTRY_IDX_W'(1);
            end else begin
              idx_d = '0;
            end
          end else if (is128) begin
            if (entry_last) begin
              idx_d = '0;
              eq_d  = 1'b1;
            end else begin
              idx_d = idx_q + ENTRY_IDX_W'(1);
              eq_d  = eq_q && byte_eq;
            end
          end
          bytes_left_d = left_dec;
          if (left_dec == 8'd0) begin
            idx_d = '0;
            eq_d  = 1'b1;
          end
        end
        default: begin
          if (beat_i.ad_byte != 8'd0) begin
            bytes_left_d = beat_i.ad_byte - 8'd1;
          end
        end
      endcase
      found_d = found_o;
      if (beat_i.final_byte) begin
        bytes_left_d = '0;
        type_d       = '0;
        idx_d        = '0;
        first_d      = '0;
        eq_d         = 1'b1;
        found_d      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_LEN;
      bytes_left_q <= '0;
      type_q       <= '0;
      idx_q        <= '0;
      first_q      <= '0;
      eq_q         <= 1'b1;
      found_q      <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      bytes_left_q <= bytes_left_d;
      type_q       <= type_d;
      idx_q        <= idx_d;
      first_q      <= first_d;
      eq_q         <= eq_d;
      found_q      <= found_d;
    end
  end

  `ADUS_ASSERT_DIS(a_data_has_bytes, clk_i, rst_ni, (phase_q == PH_DATA) |-> (bytes_left_q != 8'd0), "Data phase entered with no bytes left.")
  `ADUS_ASSERT_DIS(a_pair_index, clk_i, rst_ni, ((phase_q == PH_DATA) && is16) |-> (idx_q <= ENTRY_IDX_W'(1)), "Pair index out of range in a 16-bit list.")
  `ADUS_ASSERT_DIS(a_clear_after_final, clk_i, rst_ni, (step_i && beat_i.final_byte) |=> ((phase_q == PH_LEN) && !found_q && eq_q), "Parser state not cleared after a final byte.")

endmodule

// File: sv/adv_data_uuid_search.sv
// Top level of the advertising data service UUID search: byte register, target
// registers, parser and result register. Depends on adus_pkg, adus_if, adus_parser.
//
//   channel  | direction | beat contents
//   ad_in    | in        | ad_byte, final_byte
//   res_out  | out       | uuid_found (one beat per payload, on its final byte)
//   cfg      | in        | cfg_we_i, cfg_idx_i, cfg_data_i (write only)
//
// While input ready is high, one byte is accepted per cycle; throughput is one beat per clock.
// A result becomes valid when the result register is loaded: the edge that accepts its final
// byte loads the byte register; the result register loads when that byte steps the parser.
// Reset clears the parse state, the target registers and both valid flags.
// Input ready drops only while the byte register holds a final byte and the result register
// still holds an untaken result.
`include "adv_data_uuid_search_assert.svh"

module adv_data_uuid_search import adus_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [0:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  adus_in_if.sink          ad_in,
  adus_out_if.source       res_out
);

  logic [63:0] target_high_q;
  logic [63:0] target_low_q;
  beat_t       s1_q;
  logic        s1_valid_q;
  logic        out_valid_q;
  logic        found_q;
  logic        out_free;
  logic        s1_adv;
  logic        s1_step;
  logic        in_ready;
  logic        parser_found;

  assign out_free = !out_valid_q || res_out.ready;
  assign s1_adv   = !s1_q.final_byte || out_free;
  assign s1_step  = s1_valid_q && s1_adv;
  assign in_ready = !s1_valid_q || s1_adv;

  assign ad_in.ready        = in_ready;
  assign res_out.valid      = out_valid_q;
  assign res_out.uuid_found = found_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_high_q <= '0;
      target_low_q  <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_TARGET_HIGH) begin
        target_high_q <= cfg_data_i;
      end else begin
        target_low_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready) begin
      s1_valid_q <= ad_in.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && ad_in.valid) begin
      s1_q <= '{ad_byte: ad_in.ad_byte, final_byte: ad_in.final_byte};
    end
  end

  adus_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (s1_step),
    .beat_i       (s1_q),
    .target_high_i(target_high_q),
    .target_low_i (target_low_q),
    .found_o      (parser_found)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_step && s1_q.final_byte) begin
      out_valid_q <= 1'b1;
    end else if (res_out.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_step && s1_q.final_byte) begin
      found_q <= parser_found;
    end
  end

  `ADUS_ASSERT_DIS(a_stall_only_when_full, clk_i, rst_ni, !ad_in.ready |-> (s1_valid_q && s1_q.final_byte && out_valid_q), "Input stalled without a pending final byte.")
  `ADUS_ASSERT_DIS(a_result_from_final, clk_i, rst_ni, $rose(out_valid_q) |-> $past(s1_step && s1_q.final_byte), "Result raised without a final byte.")
  `ADUS_ASSERT_CLK(a_no_result_in_reset, clk_i, !rst_ni |=> !res_out.valid, "Result valid during reset.")

endmodule

// File: tb/sv/tb_adv_data_uuid_search.sv
// Self-checking testbench for the advertising data service UUID search.
// Feeds random and directed payloads byte by byte and checks every found flag against a
// predictor kept in the bench. Depends on adus_pkg, adus_if and adv_data_uuid_search.
module tb_adv_data_uuid_search;
  import adus_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic             cfg_we = 1'b0;
  cfg_idx_e         cfg_idx = CFG_TARGET_HIGH;
  logic [CFG_W-1:0] cfg_data = '0;

  logic       in_valid = 1'b0;
  logic [7:0] in_byte = 8'h00;
  logic       in_final = 1'b0;
  logic       out_ready = 1'b0;

  adus_in_if  ad_in_ch ();
  adus_out_if res_ch ();

  assign ad_in_ch.valid      = in_valid;
  assign ad_in_ch.ad_byte    = in_byte;
  assign ad_in_ch.final_byte = in_final;
  assign res_ch.ready        = out_ready;

  adv_data_uuid_search u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .ad_in      (ad_in_ch),
    .res_out    (res_ch)
  );

  beat_t pending_beats[$];
  logic  uuid_found_q[$];
  beat_t next_beat;
  logic  exp_found;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_len = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int err_count = 0;

  logic [63:0] tgt_high = '0;
  logic [63:0] tgt_low = '0;
  phase_e      ps_phase = PH_LEN;
  logic [7:0]  ps_left = '0;
  logic [7:0]  ps_type = '0;
  logic [3:0]  ps_idx = '0;
  logic [7:0]  ps_first = '0;
  logic        ps_equal = 1'b1;
  logic        ps_found = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    err_count++;
  endtask

  function automatic void track_ad_byte(input logic [7:0] b, input logic fin);
    logic [127:0] tgt;
    logic         eq_now;
    tgt = {tgt_high, tgt_low};
    case (ps_phase)
      PH_TYPE: begin
        ps_type  = b;
        ps_idx   = '0;
        ps_equal = 1'b1;
        ps_phase = (ps_left == 0) ? PH_LEN : PH_DATA;
      end
      PH_DATA: begin
        if (ps_type == AD_TYPE_UUID16_PART || ps_type == AD_TYPE_UUID16_FULL) begin
          if (ps_idx == 0) begin
            ps_first = b;
            ps_idx   = 4'd1;
          end else begin
            if (tgt_high == {16'h0000, b, ps_first, BASE_HIGH_LOW32} && tgt_low == BASE_LOW)
              ps_found = 1'b1;
            ps_idx = '0;
          end
        end else if (ps_type == AD_TYPE_UUID128_PART || ps_type == AD_TYPE_UUID128_FULL) begin
          eq_now = ps_equal && (b == tgt[8*ps_idx +: 8]);
          if (ps_idx == 4'(UUID128_BYTES - 1)) begin
            if (eq_now)
              ps_found = 1'b1;
            ps_idx   = '0;
            ps_equal = 1'b1;
          end else begin
            ps_idx   = ps_idx + 4'd1;
            ps_equal = eq_now;
          end
        end
        ps_left = ps_left - 8'd1;
        if (ps_left == 0) begin
          ps_phase = PH_LEN;
          ps_idx   = '0;
          ps_equal = 1'b1;
        end
      end
      default: begin
        if (b != 0) begin
          ps_left  = b - 8'd1;
          ps_phase = PH_TYPE;
        end else begin
          ps_phase = PH_LEN;
        end
      end
    endcase
    if (fin) begin
      uuid_found_q.push_back(ps_found);
      ps_phase = PH_LEN;
      ps_left  = '0;
      ps_type  = '0;
      ps_idx   = '0;
      ps_first = '0;
      ps_equal = 1'b1;
      ps_found = 1'b0;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && ad_in_ch.ready)
        track_ad_byte(in_byte, in_final);
      if (!in_valid || ad_in_ch.ready) begin
        if (pending_beats.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          next_beat = pending_beats.pop_front();
          in_valid <= 1'b1;
          in_byte  <= next_beat.ad_byte;
          in_final <= next_beat.final_byte;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_seen != hold_seq) begin
      hold_seen <= hold_seq;
      hold_left <= hold_len;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && res_ch.valid && out_ready) begin
      if (uuid_found_q.size() == 0) begin
        report_mismatch($sformatf("result uuid_found=%0b with no payload pending",
                                  res_ch.uuid_found));
      end else begin
        exp_found = uuid_found_q.pop_front();
        if (res_ch.uuid_found !== exp_found)
          report_mismatch($sformatf("uuid_found got %0b expected %0b", res_ch.uuid_found,
                                    exp_found));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic queue_payload(input logic [7:0] pl[$]);
    beat_t bt;
    for (int i = 0; i < pl.size(); i++) begin
      bt.ad_byte    = pl[i];
      bt.final_byte = (i == pl.size() - 1);
      pending_beats.push_back(bt);
    end
  endtask

  task automatic add_payload();
    logic [7:0]   pl[$];
    logic [7:0]   data[$];
    logic [127:0] tgt;
    logic [15:0]  short_id;
    logic [7:0]   v;
    bit           base_form;
    int           kind;
    int           flip;
    int           cut;
    tgt       = {tgt_high, tgt_low};
    short_id  = tgt_high[47:32];
    base_form = (tgt_high[63:48] == 0) && (tgt_high[31:0] == BASE_HIGH_LOW32) &&
                (tgt_low == BASE_LOW);
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 24)) pl.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 4)) begin
        data.delete();
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
          repeat ($urandom_range(0, 4)) begin
            if (base_form && $urandom_range(2) == 0) begin
              data.push_back(short_id[7:0]);
              data.push_back(short_id[15:8]);
            end else begin
              data.push_back(8'($urandom));
              data.push_back(8'($urandom));
            end
          end
          if ($urandom_range(3) == 0)
            data.push_back(base_form ? short_id[7:0] : 8'($urandom));
          pl.push_back(8'(data.size() + 1));
          pl.push_back($urandom_range(1) ? AD_TYPE_UUID16_PART : AD_TYPE_UUID16_FULL);
        end else if (kind < 65) begin
          repeat ($urandom_range(0, 2)) begin
            if ($urandom_range(4) == 0) begin
              repeat (UUID128_BYTES) data.push_back(8'($urandom));
            end else begin
              flip = ($urandom_range(2) == 0) ? int'($urandom_range(0, 15)) : -1;
              for (int k = 0; k < UUID128_BYTES; k++) begin
                v = tgt[8*k +: 8];
                if (k == flip)
                  v = v ^ (8'h01 << $urandom_range(7));
                data.push_back(v);
              end
            end
          end
          if ($urandom_range(3) == 0) begin
            cut = $urandom_range(1, 15);
            for (int k = 0; k < cut; k++) data.push_back(tgt[8*k +: 8]);
          end
          pl.push_back(8'(data.size() + 1));
          pl.push_back($urandom_range(1) ? AD_TYPE_UUID128_PART : AD_TYPE_UUID128_FULL);
        end else if (kind < 85) begin
          repeat ($urandom_range(0, 6)) data.push_back(8'($urandom));
          pl.push_back(8'(data.size() + 1));
          pl.push_back(8'($urandom));
        end else if (kind < 98) begin
          pl.push_back(8'h00);
        end else begin
          repeat ($urandom_range(20, 254)) data.push_back(8'($urandom));
          pl.push_back(8'(data.size() + 1));
          pl.push_back(8'($urandom));
        end
        foreach (data[i]) pl.push_back(data[i]);
      end
      if ($urandom_range(6) == 0) begin
        cut = $urandom_range(1, pl.size());
        pl  = pl[0:cut-1];
      end
    end
    queue_payload(pl);
  endtask

  task automatic wait_drained();
    while (pending_beats.size() != 0 || in_valid || uuid_found_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    if (idx == CFG_TARGET_HIGH)
      tgt_high = value;
    else
      tgt_low = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input logic [63:0] hi, input logic [63:0] lo, input int tx_pct,
                           input int rx_pct, input int n_beats, input int hold);
    int start;
    wait_drained();
    write_reg(CFG_TARGET_HIGH, hi);
    write_reg(CFG_TARGET_LOW, lo);
    @(posedge clk);
    tx_idle_pct <= tx_pct;
    rx_idle_pct <= rx_pct;
    if (hold > 0) begin
      hold_len <= hold;
      hold_seq <= hold_seq + 1;
    end
    start = pending_beats.size();
    while (pending_beats.size() - start < n_beats)
      add_payload();
  endtask

  initial begin
    logic [7:0] pl[$];
    int         guard;
    tx_idle_pct = 15;
    rx_idle_pct = 69;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // With the reset target of all zeros, a 128-bit entry of zero bytes matches.
    pl = '{8'h00};
    queue_payload(pl);
    pl = '{8'h03, AD_TYPE_UUID16_PART, 8'hFF, 8'h00, 8'h11, AD_TYPE_UUID128_FULL};
    repeat (UUID128_BYTES) pl.push_back(8'h00);
    queue_payload(pl);
    pl = '{8'hFF, AD_TYPE_UUID128_PART, 8'h00};
    queue_payload(pl);

    run_phase({16'h0000, 16'h180D, BASE_HIGH_LOW32}, BASE_LOW, 15, 69, 170, 0);
    run_phase({$urandom, $urandom}, {$urandom, $urandom}, 15, 69, 170, 0);
    run_phase('1, '1, 69, 15, 170, 0);
    run_phase({16'h0000, 16'hFFFF, BASE_HIGH_LOW32}, BASE_LOW, 69, 15, 170, 0);
    run_phase('0, '0, 0, 0, 170, 300);
    run_phase({16'h0000, 16'($urandom), BASE_HIGH_LOW32}, BASE_LOW, 0, 0, 170, 0);

    while (pending_beats.size() != 0 || in_valid)
      @(posedge clk);
    guard = 0;
    while (uuid_found_q.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (uuid_found_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", uuid_found_q.size()));
    if (err_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/adus_pkg.sv
sv/adus_if.sv
sv/adus_parser.sv
sv/adv_data_uuid_search.sv
tb/sv/tb_adv_data_uuid_search.sv
